// ===== src/assert_macros.svh =====
// Assertion macros shared by the pixel colorize and blend RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define PCAB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcab assertion failed");

// Next-cycle implication check.
`define PCAB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcab assertion failed");

`endif

// ===== src/pcab_pkg.sv =====
// Package for the pixel colorize and alpha blend block.
// Holds widths, arithmetic constants, register indexes and the pipeline control struct.
package pcab_pkg;

    localparam int CHAN_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int PROD_W      = 2 * CHAN_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int TSUM_W      = CHAN_W + 2;

    localparam int TINT_OFFSET = 20;
    localparam int FULL_SCALE  = 255;
    localparam int TINT_BIAS   = FULL_SCALE - TINT_OFFSET;

    localparam logic [CHAN_W-1:0] CHAN_MAX  = CHAN_W'(FULL_SCALE);
    localparam logic [CHAN_W-1:0] CHAN_ZERO = '0;

    localparam logic [CFG_INDEX_W-1:0] CFG_TINT_RED     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TINT_GREEN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TINT_BLUE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACK_RED     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACK_GREEN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACK_BLUE    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_ENABLE = 3'd6;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
        logic s4_en;
        logic blend3;
    } pipe_ctrl_t;

endpackage

// ===== src/pcab_in_if.sv =====
// Input channel interface: one source pixel per transaction.
// Depends on pcab_pkg for the channel width.
interface pcab_in_if;
    logic                        valid;
    logic                        ready;
    logic [pcab_pkg::CHAN_W-1:0] pixel_alpha;
    logic [pcab_pkg::CHAN_W-1:0] pixel_intensity;

    modport source (output valid, output pixel_alpha, output pixel_intensity, input ready);
    modport sink   (input valid, input pixel_alpha, input pixel_intensity, output ready);
endinterface

// ===== src/pcab_out_if.sv =====
// Output channel interface: one RGBA result pixel per transaction.
// Depends on pcab_pkg for the channel width.
interface pcab_out_if;
    logic                        valid;
    logic                        ready;
    logic [pcab_pkg::CHAN_W-1:0] out_red;
    logic [pcab_pkg::CHAN_W-1:0] out_green;
    logic [pcab_pkg::CHAN_W-1:0] out_blue;
    logic [pcab_pkg::CHAN_W-1:0] out_alpha;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, output ready);
endinterface

// ===== src/pcab_channel.sv =====
// Datapath of one color channel: tint and clamp, products, sum, divide by 255 and select.
// Depends on pcab_pkg; stage enables and the blend flag come from the top level.
module pcab_channel
(
    input  logic                        clk,
    input  pcab_pkg::pipe_ctrl_t        ctrl,
    input  logic [pcab_pkg::CHAN_W-1:0] tint,
    input  logic [pcab_pkg::CHAN_W-1:0] back,
    input  logic [pcab_pkg::CHAN_W-1:0] intensity,
    input  logic [pcab_pkg::CHAN_W-1:0] alpha1,
    output logic [pcab_pkg::CHAN_W-1:0] chan_out
);

    logic [pcab_pkg::TSUM_W-1:0] tsum;
    logic [pcab_pkg::CHAN_W-1:0] tint1_next;
    logic [pcab_pkg::CHAN_W-1:0] tint1_reg;
    logic [pcab_pkg::CHAN_W-1:0] inv1;
    logic [pcab_pkg::PROD_W-1:0] pfg2_next;
    logic [pcab_pkg::PROD_W-1:0] pbg2_next;
    logic [pcab_pkg::PROD_W-1:0] pfg2_reg;
    logic [pcab_pkg::PROD_W-1:0] pbg2_reg;
    logic [pcab_pkg::CHAN_W-1:0] tint2_reg;
    logic [pcab_pkg::SUM_W-1:0]  sum3_next;
    logic [pcab_pkg::SUM_W-1:0]  sum3_reg;
    logic [pcab_pkg::CHAN_W-1:0] tint3_reg;
    logic [pcab_pkg::SUM_W-1:0]  quot_acc;
    logic [pcab_pkg::CHAN_W-1:0] quot;
    logic [pcab_pkg::CHAN_W-1:0] out4_next;
    logic [pcab_pkg::CHAN_W-1:0] out4_reg;

    always_comb
    begin
        tsum = pcab_pkg::TSUM_W'(tint) + pcab_pkg::TSUM_W'(intensity);
        if (tsum < pcab_pkg::TSUM_W'(pcab_pkg::TINT_BIAS))
        begin
            tint1_next = pcab_pkg::CHAN_ZERO;
        end
        else if (tsum > pcab_pkg::TSUM_W'(pcab_pkg::TINT_BIAS + pcab_pkg::FULL_SCALE))
        begin
            tint1_next = pcab_pkg::CHAN_MAX;
        end
        else
        begin
            tint1_next = pcab_pkg::CHAN_W'(tsum - pcab_pkg::TSUM_W'(pcab_pkg::TINT_BIAS));
        end
    end

    assign inv1      = pcab_pkg::CHAN_MAX - alpha1;
    assign pfg2_next = pcab_pkg::PROD_W'(alpha1) * pcab_pkg::PROD_W'(tint1_reg);
    assign pbg2_next = pcab_pkg::PROD_W'(inv1) * pcab_pkg::PROD_W'(back);
    assign sum3_next = pcab_pkg::SUM_W'(pfg2_reg) + pcab_pkg::SUM_W'(pbg2_reg);

    // The sum never exceeds 255 * 255, where (s + 1 + s / 256) / 256 equals s / 255.
    assign quot_acc  = sum3_reg + pcab_pkg::SUM_W'(1)
                     + pcab_pkg::SUM_W'(sum3_reg[pcab_pkg::SUM_W-1:pcab_pkg::CHAN_W]);
    assign quot      = quot_acc[pcab_pkg::PROD_W-1:pcab_pkg::CHAN_W];
    assign out4_next = ctrl.blend3 ? quot : tint3_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_en)
        begin
            tint1_reg <= tint1_next;
        end
        if (ctrl.s2_en)
        begin
            pfg2_reg  <= pfg2_next;
            pbg2_reg  <= pbg2_next;
            tint2_reg <= tint1_reg;
        end
        if (ctrl.s3_en)
        begin
            sum3_reg  <= sum3_next;
            tint3_reg <= tint2_reg;
        end
        if (ctrl.s4_en)
        begin
            out4_reg <= out4_next;
        end
    end

    assign chan_out = out4_reg;

endmodule

// ===== src/pixel_colorize_alpha_blend.sv =====
// Pixel colorize and alpha blend, top level: configuration registers, pipeline control, alpha path.
// Depends on pcab_pkg, pcab_in_if, pcab_out_if, pcab_channel and assert_macros.svh.
// A pixel accepted into stage one moves through stages two and three to the output register
// of stage four, where it shows as a valid result.
// One pixel per cycle unless stalled; four register stages, each with its own valid bit.
// A stalled output holds only as many stages as are full; empty stages keep accepting.
// Reset clears all stage valid bits and sets every configuration register to zero.
`include "assert_macros.svh"

module pixel_colorize_alpha_blend
(
    input  logic                             clk,
    input  logic                             rst_n,
    pcab_in_if.sink                          pix_in,
    pcab_out_if.source                       pix_out,
    input  logic                             cfg_we,
    input  logic [pcab_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pcab_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [pcab_pkg::CHAN_W-1:0] tint_red_reg;
    logic [pcab_pkg::CHAN_W-1:0] tint_green_reg;
    logic [pcab_pkg::CHAN_W-1:0] tint_blue_reg;
    logic [pcab_pkg::CHAN_W-1:0] back_red_reg;
    logic [pcab_pkg::CHAN_W-1:0] back_green_reg;
    logic [pcab_pkg::CHAN_W-1:0] back_blue_reg;
    logic                        blend_enable_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    logic [pcab_pkg::CHAN_W-1:0] alpha1_reg, alpha2_reg, alpha3_reg, alpha4_reg;
    logic [pcab_pkg::CHAN_W-1:0] alpha4_next;
    logic blend1_next;
    logic blend1_reg, blend2_reg, blend3_reg, blend4_reg;
    pcab_pkg::pipe_ctrl_t ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_red_reg     <= '0;
            tint_green_reg   <= '0;
            tint_blue_reg    <= '0;
            back_red_reg     <= '0;
            back_green_reg   <= '0;
            back_blue_reg    <= '0;
            blend_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcab_pkg::CFG_TINT_RED:     tint_red_reg     <= cfg_data;
                pcab_pkg::CFG_TINT_GREEN:   tint_green_reg   <= cfg_data;
                pcab_pkg::CFG_TINT_BLUE:    tint_blue_reg    <= cfg_data;
                pcab_pkg::CFG_BACK_RED:     back_red_reg     <= cfg_data;
                pcab_pkg::CFG_BACK_GREEN:   back_green_reg   <= cfg_data;
                pcab_pkg::CFG_BACK_BLUE:    back_blue_reg    <= cfg_data;
                pcab_pkg::CFG_BLEND_ENABLE: blend_enable_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    assign en4 = !v4_reg || pix_out.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign pix_in.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= pix_in.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    assign blend1_next = blend_enable_reg
                      && (pix_in.pixel_alpha != pcab_pkg::CHAN_ZERO)
                      && (pix_in.pixel_alpha != pcab_pkg::CHAN_MAX);
    assign alpha4_next = blend3_reg ? pcab_pkg::CHAN_MAX : alpha3_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            alpha1_reg <= pix_in.pixel_alpha;
            blend1_reg <= blend1_next;
        end
        if (en2)
        begin
            alpha2_reg <= alpha1_reg;
            blend2_reg <= blend1_reg;
        end
        if (en3)
        begin
            alpha3_reg <= alpha2_reg;
            blend3_reg <= blend2_reg;
        end
        if (en4)
        begin
            alpha4_reg <= alpha4_next;
            blend4_reg <= blend3_reg;
        end
    end

    assign ctrl.s1_en  = en1;
    assign ctrl.s2_en  = en2;
    assign ctrl.s3_en  = en3;
    assign ctrl.s4_en  = en4;
    assign ctrl.blend3 = blend3_reg;

    pcab_channel u_red
    (
        .clk       (clk),
        .ctrl      (ctrl),
        .tint      (tint_red_reg),
        .back      (back_red_reg),
        .intensity (pix_in.pixel_intensity),
        .alpha1    (alpha1_reg),
        .chan_out  (pix_out.out_red)
    );

    pcab_channel u_green
    (
        .clk       (clk),
        .ctrl      (ctrl),
        .tint      (tint_green_reg),
        .back      (back_green_reg),
        .intensity (pix_in.pixel_intensity),
        .alpha1    (alpha1_reg),
        .chan_out  (pix_out.out_green)
    );

    pcab_channel u_blue
    (
        .clk       (clk),
        .ctrl      (ctrl),
        .tint      (tint_blue_reg),
        .back      (back_blue_reg),
        .intensity (pix_in.pixel_intensity),
        .alpha1    (alpha1_reg),
        .chan_out  (pix_out.out_blue)
    );

    assign pix_out.valid     = v4_reg;
    assign pix_out.out_alpha = alpha4_reg;

    // A blocked input means the output stage holds a result that is not being taken.
    `PCAB_ASSERT_NOW(a_stall_source, !pix_in.ready, pix_out.valid && !pix_out.ready)
    // Only partially transparent pixels are ever marked for blending.
    `PCAB_ASSERT_NOW(a_blend_alpha, v1_reg && blend1_reg,
                     (alpha1_reg != pcab_pkg::CHAN_ZERO) && (alpha1_reg != pcab_pkg::CHAN_MAX))
    // A blended result always leaves with full alpha.
    `PCAB_ASSERT_NOW(a_blend_opaque, pix_out.valid && blend4_reg,
                     pix_out.out_alpha == pcab_pkg::CHAN_MAX)

endmodule
